@@ rtl/rau_pkg.sv @@
`default_nettype none

package rau_pkg;

    // operand width of the input fractions
    localparam int OPERAND_WIDTH = 16;

    localparam int MUL_W     = OPERAND_WIDTH + 1;          // multiplier operand
    localparam int PROD_W    = 2 * MUL_W;                  // multiplier product
    localparam int ACC_W     = 2 * OPERAND_WIDTH + 1;      // signed working value
    localparam int MAG_W     = 2 * OPERAND_WIDTH;          // magnitude for gcd / divide
    localparam int MAG_CNT_W = $clog2(MAG_W + 1);
    localparam int EXT_W     = 64;
    localparam int NUM_OUT_W = 33;
    localparam int DEN_OUT_W = 31;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } rau_action_t;

    typedef struct packed {
        rau_action_t                      action;
        logic signed [OPERAND_WIDTH-1:0]  a_num;
        logic signed [OPERAND_WIDTH-1:0]  a_den;
        logic signed [OPERAND_WIDTH-1:0]  b_num;
        logic signed [OPERAND_WIDTH-1:0]  b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [NUM_OUT_W-1:0] result_num;
        logic        [DEN_OUT_W-1:0] result_den;
    } rau_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_CHK,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_END,
        ST_FINISH
    } rau_state_t;

endpackage

`default_nettype wire

@@ rtl/rau_mult.sv @@
`default_nettype none

module rau_mult (
    input  wire logic                              aclk,
    input  wire logic signed [rau_pkg::MUL_W-1:0]  x,
    input  wire logic signed [rau_pkg::MUL_W-1:0]  y,
    output logic signed [rau_pkg::PROD_W-1:0]      p_reg
);
    import rau_pkg::*;

    logic signed [PROD_W-1:0] p_next;

    // signed product, registered before use
    always_comb begin
        p_next = PROD_W'(x) * PROD_W'(y);
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

endmodule

`default_nettype wire

@@ rtl/rau_gcd.sv @@
`default_nettype none

module rau_gcd (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rau_pkg::MAG_W-1:0]  u_in,
    input  wire logic [rau_pkg::MAG_W-1:0]  v_in,
    output logic                            done_reg,
    output logic [rau_pkg::MAG_W-1:0]       g_reg
);
    import rau_pkg::*;

    logic [MAG_W-1:0]     u_reg, u_next;
    logic [MAG_W-1:0]     v_reg, v_next;
    logic [MAG_CNT_W-1:0] k_reg, k_next;
    logic                 busy_reg, busy_next;
    logic                 done_next;
    logic [MAG_W-1:0]     g_next;
    logic                 u_gt_v;
    logic [MAG_W-1:0]     big, little, diff;

    // binary gcd, one step per cycle; both operands nonzero
    always_comb begin
        u_gt_v    = u_reg > v_reg;
        big       = u_gt_v ? u_reg : v_reg;
        little    = u_gt_v ? v_reg : u_reg;
        diff      = big - little;
        u_next    = u_reg;
        v_next    = v_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        g_next    = g_reg;
        if (start) begin
            u_next    = u_in;
            v_next    = v_in;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (u_reg == v_reg) begin
                g_next    = MAG_W'(u_reg << k_reg);
                done_next = 1'b1;
                busy_next = 1'b0;
            end else if (!u_reg[0] && !v_reg[0]) begin
                u_next = u_reg >> 1;
                v_next = v_reg >> 1;
                k_next = k_reg + MAG_CNT_W'(1);
            end else if (!u_reg[0]) begin
                u_next = u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_next = v_reg >> 1;
            end else if (u_gt_v) begin
                u_next = diff >> 1;
            end else begin
                v_next = diff >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        u_reg <= u_next;
        v_reg <= v_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

endmodule

`default_nettype wire

@@ rtl/rau_div.sv @@
`default_nettype none

module rau_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rau_pkg::MAG_W-1:0]  dividend,
    input  wire logic [rau_pkg::MAG_W-1:0]  divisor,
    output logic                            done_reg,
    output logic [rau_pkg::MAG_W-1:0]       quo_reg
);
    import rau_pkg::*;

    logic [MAG_W-1:0]     rem_reg, rem_next;
    logic [MAG_W-1:0]     quo_next;
    logic [MAG_W-1:0]     dvs_reg, dvs_next;
    logic [MAG_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_next;
    logic [MAG_W:0]       rem_sh;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[MAG_W-1]};
        fits      = rem_sh >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = MAG_CNT_W'(MAG_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? MAG_W'(rem_sh - {1'b0, dvs_reg}) : MAG_W'(rem_sh);
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg - MAG_CNT_W'(1);
            if (cnt_reg == MAG_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

endmodule

`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
`default_nettype none

// rational arithmetic unit: adds, subtracts, multiplies or divides two fractions
// input channel s_valid / s_ready / s_data carries the operation and both fractions;
// result channel m_valid / m_ready / m_data carries the normalised, reduced fraction
// one input transfer gives exactly one result transfer, in order
// the product terms come from one registered multiplier, two products for multiply
// and divide, three for add and subtract; normalising then takes a sign fix and,
// unless the numerator is zero, a binary gcd (one step per cycle) and, unless the
// gcd is one, two restoring divisions through one shared divider; divide runs two
// passes (reciprocal of b first, on 16-bit values)
// s_ready is high only while the sequencer is idle; one item is in work at a time
// the finished result sits in an output register, so a new item may be taken while
// the receiver stalls; if the register is still full when the next result is ready
// the sequencer waits for m_ready
// reset (aresetn low, synchronous) empties the output register and idles the sequencer
module rational_arithmetic_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rau_pkg::rau_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rau_pkg::rau_out_t      m_data
);
    import rau_pkg::*;

    // sequencer state
    rau_state_t  state_reg, state_next;

    // captured operands
    rau_action_t                     op_reg, op_next;
    logic signed [OPERAND_WIDTH-1:0] an_reg, an_next;
    logic signed [OPERAND_WIDTH-1:0] ad_reg, ad_next;
    logic signed [OPERAND_WIDTH-1:0] bn_reg, bn_next;
    logic signed [OPERAND_WIDTH-1:0] bd_reg, bd_next;

    // working fraction; holds b's reciprocal during the first pass of a divide
    logic signed [ACC_W-1:0] n_reg, n_next;
    logic signed [ACC_W-1:0] d_reg, d_next;
    logic [1:0]              step_reg, step_next;
    logic                    recip_reg, recip_next;

    // result register
    rau_out_t out_reg, out_next;
    logic     m_valid_reg, m_valid_next;
    logic     out_free;

    // shared units
    logic signed [MUL_W-1:0]  mul_x, mul_y;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [ACC_W-1:0]  prod;
    logic                     gcd_start, gcd_done;
    logic [MAG_W-1:0]         gcd_u, gcd_v, gcd_g;
    logic                     div_start, div_done;
    logic [MAG_W-1:0]         div_dividend, div_q;

    logic [MAG_W-1:0]         n_mag;
    logic signed [ACC_W-1:0]  q_signed;
    logic signed [EXT_W-1:0]  n_wide, d_wide;
    logic                     two_products;

    rau_mult u_mult (
        .aclk  (aclk),
        .x     (mul_x),
        .y     (mul_y),
        .p_reg (mul_p)
    );

    rau_gcd u_gcd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (gcd_start),
        .u_in     (gcd_u),
        .v_in     (gcd_v),
        .done_reg (gcd_done),
        .g_reg    (gcd_g)
    );

    rau_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (gcd_g),
        .done_reg (div_done),
        .quo_reg  (div_q)
    );

    always_comb begin
        prod         = ACC_W'(mul_p);
        n_mag        = n_reg[ACC_W-1] ? MAG_W'(-n_reg) : MAG_W'(n_reg);
        q_signed     = n_reg[ACC_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        out_free     = !m_valid_reg || m_ready;
        // multiply and divide need only numerator and denominator products
        two_products = (op_reg == ACT_MUL) || (op_reg == ACT_DIV);
        n_wide       = EXT_W'(n_reg);
        d_wide       = EXT_W'(d_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.action == ACT_DIV) ? ST_FIX : ST_MUL;
                end
            end
            ST_MUL: begin
                if ((step_reg == 2'd2 && two_products) || step_reg == 2'd3) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:  state_next = ST_CHK;
            ST_CHK:  state_next = (n_reg == '0) ? ST_END : ST_GCD;
            ST_GCD: begin
                if (gcd_done) begin
                    state_next = (gcd_g == MAG_W'(1)) ? ST_END : ST_DIVN;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    state_next = ST_END;
                end
            end
            ST_END:  state_next = recip_reg ? ST_MUL : ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // unit controls and operand selection
    always_comb begin
        s_ready      = 1'b0;
        gcd_start    = 1'b0;
        gcd_u        = n_mag;
        gcd_v        = MAG_W'(d_reg);
        div_start    = 1'b0;
        div_dividend = n_mag;
        mul_x        = MUL_W'(an_reg);
        mul_y        = MUL_W'(bd_reg);
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_MUL: begin
                case (step_reg)
                    2'd0: begin
                        mul_x = MUL_W'(an_reg);
                        if (op_reg == ACT_DIV) begin
                            mul_y = MUL_W'(n_reg);
                        end else if (op_reg == ACT_MUL) begin
                            mul_y = MUL_W'(bn_reg);
                        end else begin
                            mul_y = MUL_W'(bd_reg);
                        end
                    end
                    2'd1: begin
                        mul_x = MUL_W'(ad_reg);
                        mul_y = (op_reg == ACT_DIV) ? MUL_W'(d_reg) : MUL_W'(bd_reg);
                    end
                    default: begin
                        mul_x = MUL_W'(bn_reg);
                        mul_y = MUL_W'(ad_reg);
                    end
                endcase
            end
            ST_CHK:  gcd_start = (n_reg != '0);
            ST_GCD:  div_start = gcd_done && (gcd_g != MAG_W'(1));
            ST_DIVN: begin
                div_start    = div_done;
                div_dividend = MAG_W'(d_reg);
            end
            default: ;
        endcase
    end

    // working registers
    always_comb begin
        op_next      = op_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        step_next    = step_reg;
        recip_next   = recip_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.action;
                    an_next    = s_data.a_num;
                    ad_next    = s_data.a_den;
                    bn_next    = s_data.b_num;
                    bd_next    = s_data.b_den;
                    step_next  = 2'd0;
                    recip_next = (s_data.action == ACT_DIV);
                    // reciprocal of b goes through normalising first
                    n_next     = ACC_W'(s_data.b_den);
                    d_next     = ACC_W'(s_data.b_num);
                end
            end
            ST_MUL: begin
                step_next = step_reg + 2'd1;
                case (step_reg)
                    2'd1:    n_next = prod;
                    2'd2:    d_next = prod;
                    2'd3:    n_next = (op_reg == ACT_SUB) ? n_reg - prod : n_reg + prod;
                    default: ;
                endcase
            end
            ST_FIX: begin
                if (d_reg == '0) begin
                    d_next = ACC_W'(1);
                end else if (d_reg[ACC_W-1]) begin
                    n_next = -n_reg;
                    d_next = -d_reg;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    n_next = q_signed;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    d_next = $signed({1'b0, div_q});
                end
            end
            ST_END: begin
                recip_next = 1'b0;
                step_next  = 2'd0;
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_next.result_num = n_wide[NUM_OUT_W-1:0];
                    out_next.result_den = d_wide[DEN_OUT_W-1:0];
                    m_valid_next        = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg    <= op_next;
        an_reg    <= an_next;
        ad_reg    <= ad_next;
        bn_reg    <= bn_next;
        bd_reg    <= bd_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        step_reg  <= step_next;
        recip_reg <= recip_next;
        out_reg   <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // a delivered denominator is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.result_den != '0)
        else $error("zero denominator delivered");

    // after the sign fix the denominator is strictly positive
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIX |=> !d_reg[ACC_W-1] && d_reg != '0)
        else $error("denominator not positive after sign fix");

    // an accepted item always leaves the idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted item not started");

    // the gcd of two nonzero values is nonzero
    assert property (@(posedge aclk) disable iff (!aresetn)
        gcd_done |-> gcd_g != '0)
        else $error("gcd returned zero");

endmodule

`default_nettype wire
